>>> rtl/core/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CHK_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CHK_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/dtsl_pkg.sv
// shared constants and types of the dds tuning word serial loader
package dtsl_pkg;

    localparam int FREQ_W  = 28;
    localparam int PHASE_W = 5;
    localparam int WORD_W  = 32;
    localparam int CTRL_W  = 8;
    localparam int FRAME_W = WORD_W + CTRL_W;
    localparam int EVCNT_W = $clog2(FRAME_W + 1);
    localparam int DIVCNT_W = $clog2(WORD_W);

    localparam logic [FREQ_W-1:0] REF_RESET   = FREQ_W'(125000000);
    localparam logic [CTRL_W-1:0] PDOWN_CTRL  = 8'h04;
    localparam int                PHASE_SHIFT = 3;

    // request codes
    localparam logic [1:0] REQ_SET   = 2'd0;
    localparam logic [1:0] REQ_PDOWN = 2'd1;
    localparam logic [1:0] REQ_WAKE  = 2'd2;

    // event kinds
    localparam logic EV_BIT   = 1'b0;
    localparam logic EV_PULSE = 1'b1;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quotient;
    } t_div_res;

endpackage

>>> rtl/core/dds_tuning_word_serial_loader_top.sv
// top level of the dds tuning word serial loader
//
// usage
//   input channel (i_in_valid / o_in_stall) takes one request per transfer:
//   set (frequency and phase), power down or wake up; code 3 is dropped.
//   output channel (o_out_valid / i_out_stall) gives one event per transfer:
//   a serial data bit or a frequency update pulse, o_last on the final one.
//   i_cfg_wr_en / i_cfg_wr_data write the reference clock; write only while idle.
// sequencing
//   set: the serial divider gives one quotient bit a cycle, or saturates the
//   word without iterating, then 41 events follow at one a cycle while the
//   receiver does not stall. wake up: 41 events, power down: 10 events,
//   the first entering the output register from the send state once it is free.
//   the sequencer and the divider handle one request at a time, so
//   o_in_stall stays high until the last event has entered the output register.
// reset
//   synchronous, active low: stored word and phase clear to zero, the
//   reference clock returns to 125 MHz, no event is pending.
// receiver stall
//   the output register holds its event and the sequencer waits; nothing
//   is lost or repeated.
`include "assert_macros.svh"

module dds_tuning_word_serial_loader_top
    import dtsl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_wr_en,
    input  logic [FREQ_W-1:0]  i_cfg_wr_data,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic [FREQ_W-1:0]  i_freq_hz,
    input  logic [PHASE_W-1:0] i_phase_code,
    // event channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_event_kind,
    output logic               o_data_bit,
    output logic               o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SEND
    } t_state;

    t_state               r_state;
    logic [FREQ_W-1:0]    r_ref_clock_hz;
    logic [WORD_W-1:0]    r_tuning_word;
    logic [PHASE_W-1:0]   r_stored_phase;

    // event sequencer: optional leading pulse, shifted bits, closing pulse
    logic [FRAME_W-1:0]   r_shift;
    logic [EVCNT_W-1:0]   r_bits_left;
    logic                 r_pre_pulse;

    logic                 w_in_xfer;
    logic                 w_slot_free;
    logic                 w_div_start;
    t_div_res             w_div;
    logic [CTRL_W-1:0]    w_ctrl_stored;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_slot_free = !o_out_valid || !i_out_stall;
    assign w_div_start = w_in_xfer && (i_req_type == REQ_SET);

    // control byte carries the phase in its top five bits
    assign w_ctrl_stored = CTRL_W'(r_stored_phase) << PHASE_SHIFT;

    // reference clock register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_clock_hz <= REF_RESET;
        end else if (i_cfg_wr_en) begin
            r_ref_clock_hz <= i_cfg_wr_data;
        end
    end

    dtsl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_freq_hz),
        .i_divisor  (r_ref_clock_hz),
        .o_res      (w_div)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_tuning_word  <= '0;
            r_stored_phase <= '0;
            r_bits_left    <= '0;
            r_pre_pulse    <= 1'b0;
            o_out_valid    <= 1'b0;
        end else begin
            // event taken by the receiver frees the output register;
            // in the send state the sequencer refills it in the same cycle
            if (o_out_valid && !i_out_stall && (r_state != S_SEND)) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        case (i_req_type)
                            REQ_SET: begin
                                r_stored_phase <= i_phase_code;
                                r_state        <= S_DIV;
                            end
                            REQ_PDOWN: begin
                                r_shift     <= FRAME_W'(PDOWN_CTRL);
                                r_bits_left <= EVCNT_W'(CTRL_W);
                                r_pre_pulse <= 1'b1;
                                r_state     <= S_SEND;
                            end
                            REQ_WAKE: begin
                                // resend from a copy, the stored word is kept
                                r_shift     <= {w_ctrl_stored, r_tuning_word};
                                r_bits_left <= EVCNT_W'(FRAME_W);
                                r_pre_pulse <= 1'b0;
                                r_state     <= S_SEND;
                            end
                            default: begin
                                // unused code: dropped
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_div.done) begin
                        r_tuning_word <= w_div.quotient;
                        r_shift       <= {w_ctrl_stored, w_div.quotient};
                        r_bits_left   <= EVCNT_W'(FRAME_W);
                        r_pre_pulse   <= 1'b0;
                        r_state       <= S_SEND;
                    end
                end
                S_SEND: begin
                    if (w_slot_free) begin
                        o_out_valid <= 1'b1;
                        if (r_pre_pulse) begin
                            r_pre_pulse  <= 1'b0;
                            o_event_kind <= EV_PULSE;
                            o_data_bit   <= 1'b0;
                            o_last       <= 1'b0;
                        end else if (r_bits_left != '0) begin
                            o_event_kind <= EV_BIT;
                            o_data_bit   <= r_shift[0];
                            o_last       <= 1'b0;
                            r_shift      <= r_shift >> 1;
                            r_bits_left  <= r_bits_left - 1'b1;
                        end else begin
                            // closing frequency update pulse
                            o_event_kind <= EV_PULSE;
                            o_data_bit   <= 1'b0;
                            o_last       <= 1'b1;
                            r_state      <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // the final event of every request is a pulse
    `CHK_SAME(a_last_is_pulse, i_clk, i_rst_n, o_out_valid && o_last,
        o_event_kind == EV_PULSE, "last event is not a pulse")
    // divider reports only while a set request waits for it
    `CHK_SAME(a_div_done_in_div, i_clk, i_rst_n, w_div.done, r_state == S_DIV,
        "divider done outside divide state")
    // a set request starts the divide
    `CHK_NEXT(a_set_enters_div, i_clk, i_rst_n, w_div_start, r_state == S_DIV,
        "set request did not start divide")
    // bit counter never exceeds one frame
    `CHK_SAME(a_count_bound, i_clk, i_rst_n, r_state == S_SEND,
        r_bits_left <= EVCNT_W'(FRAME_W), "bit counter out of range")

endmodule

>>> rtl/core/dtsl_div.sv
// serial restoring divider for floor(freq * 2^32 / ref) with saturation
module dtsl_div
    import dtsl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [FREQ_W-1:0] i_dividend,
    input  logic [FREQ_W-1:0] i_divisor,
    output t_div_res          o_res
);

    logic                r_busy;
    logic                r_done;
    logic [DIVCNT_W-1:0] r_cnt;
    logic [FREQ_W-1:0]   r_rem;
    logic [FREQ_W-1:0]   r_div;
    logic [WORD_W-1:0]   r_quo;

    logic [FREQ_W:0]     n_shifted;
    logic                n_ge;
    logic [FREQ_W:0]     n_diff;
    logic [FREQ_W-1:0]   n_rem;

    // one quotient bit per cycle
    always_comb begin
        n_shifted = {r_rem, 1'b0};
        n_ge      = (n_shifted >= {1'b0, r_div});
        n_diff    = n_shifted - {1'b0, r_div};
        n_rem     = n_ge ? n_diff[FREQ_W-1:0] : n_shifted[FREQ_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_div <= i_divisor;
                r_rem <= i_dividend;
                r_cnt <= '1;
                if ((i_divisor == '0) || (i_dividend >= i_divisor)) begin
                    // quotient would not fit in the word: saturate
                    r_quo  <= '1;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[WORD_W-2:0], n_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done     = r_done;
    assign o_res.quotient = r_quo;

endmodule

>>> tb/dds_tuning_word_serial_loader_top_tb.sv
// self-checking testbench of the dds tuning word serial loader top level
`timescale 1ns / 1ps

module dds_tuning_word_serial_loader_top_tb;
    import dtsl_pkg::*;

    // unused request code, dropped by the block without any event
    localparam logic [1:0] REQ_NONE = 2'd3;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 4;
    localparam int IDLE_PCT      = 33;
    // extra cycles waited once the queues and the owed events have drained
    localparam int SETTLE_CYCLES = 120;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 50;
    localparam int N_PHASES      = 8;

    typedef struct packed {
        logic [1:0]         req;
        logic [FREQ_W-1:0]  freq;
        logic [PHASE_W-1:0] phase;
    } t_dds_req;

    typedef struct packed {
        logic kind;
        logic data;
        logic is_last;
    } t_serial_event;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_wr_en   = 1'b0;
    logic [FREQ_W-1:0]  i_cfg_wr_data = '0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_req_type    = REQ_SET;
    logic [FREQ_W-1:0]  i_freq_hz     = '0;
    logic [PHASE_W-1:0] i_phase_code  = '0;
    logic               o_out_valid;
    logic               i_out_stall   = 1'b0;
    logic               o_event_kind;
    logic               o_data_bit;
    logic               o_last;

    dds_tuning_word_serial_loader_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_freq_hz     (i_freq_hz),
        .i_phase_code  (i_phase_code),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_event_kind  (o_event_kind),
        .o_data_bit    (o_data_bit),
        .o_last        (o_last)
    );

    // requests waiting for the driver, and the serial events still owed by the block
    t_dds_req      pending_reqs[$];
    t_serial_event owed_events[$];

    // shadow of the block state and its reference clock register
    logic [WORD_W-1:0]  tw_model;
    logic [PHASE_W-1:0] phase_model;
    logic [FREQ_W-1:0]  ref_clk_model;

    t_dds_req cur_req;
    bit       item_held = 1'b0;
    bit       quiet     = 1'b0;

    int n_errors   = 0;
    int n_checked  = 0;
    int n_set      = 0;
    int n_pdown    = 0;
    int n_wake     = 0;
    int n_ignored  = 0;
    int n_settings = 1;
    int cycle_cnt  = 0;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    function automatic logic [WORD_W-1:0] tuning_word_of(logic [FREQ_W-1:0] freq,
                                                         logic [FREQ_W-1:0] ref_clk);
        logic [63:0] num;
        logic [63:0] quo;
        // no divisor means saturation, as does any quotient above 32 bits
        if (ref_clk == '0)
            return '1;
        num = 64'(freq) << WORD_W;
        quo = num / 64'(ref_clk);
        if (quo[63:WORD_W] != '0)
            return '1;
        return quo[WORD_W-1:0];
    endfunction

    task automatic owe_event(logic kind, logic data, logic is_last);
        t_serial_event ev;
        ev.kind    = kind;
        ev.data    = data;
        ev.is_last = is_last;
        owed_events.push_back(ev);
    endtask

    // stored word lsb first, then the control byte, then the update pulse
    task automatic owe_frame();
        logic [CTRL_W-1:0] ctrl;
        ctrl = CTRL_W'(phase_model) << PHASE_SHIFT;
        for (int i = 0; i < WORD_W; i++)
            owe_event(EV_BIT, tw_model[i], 1'b0);
        for (int i = 0; i < CTRL_W; i++)
            owe_event(EV_BIT, ctrl[i], 1'b0);
        owe_event(EV_PULSE, 1'b0, 1'b1);
    endtask

    task automatic predict_events(t_dds_req r);
        case (r.req)
            REQ_SET: begin
                tw_model    = tuning_word_of(r.freq, ref_clk_model);
                phase_model = r.phase;
                owe_frame();
                n_set++;
            end
            REQ_PDOWN: begin
                // stored word and phase are left alone
                owe_event(EV_PULSE, 1'b0, 1'b0);
                for (int i = 0; i < CTRL_W; i++)
                    owe_event(EV_BIT, PDOWN_CTRL[i], 1'b0);
                owe_event(EV_PULSE, 1'b0, 1'b1);
                n_pdown++;
            end
            REQ_WAKE: begin
                owe_frame();
                n_wake++;
            end
            default: begin
                n_ignored++;
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // request driver: presents queued requests with random gaps
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin
        bit take_next;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            take_next = 1'b0;
            if (i_in_valid && !o_in_stall) begin
                // transfer of the presented request
                predict_events(cur_req);
                item_held = 1'b0;
                take_next = 1'b1;
            end else if (!i_in_valid) begin
                take_next = 1'b1;
            end
            // a stalled request holds valid and payload untouched
            if (take_next) begin
                if (pending_reqs.size() != 0 &&
                    (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    cur_req = pending_reqs.pop_front();
                    item_held = 1'b1;
                    i_in_valid   <= 1'b1;
                    i_req_type   <= cur_req.req;
                    i_freq_hz    <= cur_req.freq;
                    i_phase_code <= cur_req.phase;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // event monitor: random receiver stall, compares each transfer
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin
        t_serial_event want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (owed_events.size() == 0) begin
                    $display("%0t: unexpected event: kind %0d bit %0d last %0d",
                             $time, o_event_kind, o_data_bit, o_last);
                    n_errors++;
                end else begin
                    want = owed_events.pop_front();
                    if (o_event_kind !== want.kind || o_data_bit !== want.data ||
                        o_last !== want.is_last) begin
                        $display("%0t: event mismatch: expected kind %0d bit %0d last %0d, got kind %0d bit %0d last %0d",
                                 $time, want.kind, want.data, want.is_last,
                                 o_event_kind, o_data_bit, o_last);
                        n_errors++;
                    end
                    n_checked++;
                end
            end
            i_out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d events still owed", $time, owed_events.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    task automatic queue_req(logic [1:0] req, logic [FREQ_W-1:0] freq,
                             logic [PHASE_W-1:0] phase);
        t_dds_req r;
        r.req   = req;
        r.freq  = freq;
        r.phase = phase;
        pending_reqs.push_back(r);
    endtask

    // wait until the block has nothing left to do, then let it settle
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || item_held || owed_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_ref_clk(logic [FREQ_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        ref_clk_model = value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [FREQ_W-1:0] pick_freq(logic [FREQ_W-1:0] ref_clk);
        logic [FREQ_W-1:0] f;
        case ($urandom_range(0, 9))
            0:       f = '0;
            1:       f = '1;
            3, 4, 5: f = (ref_clk != '0) ? FREQ_W'($urandom % ref_clk) : FREQ_W'($urandom);
            6:       f = (ref_clk != '0) ? ref_clk - 1'b1 : '0;
            7:       f = ref_clk;
            8:       f = FREQ_W'($urandom_range(0, 1000));
            default: f = FREQ_W'($urandom);
        endcase
        return f;
    endfunction

    // random requests, mostly sets; dropped codes do not count toward n
    task automatic queue_random(int n);
        int  cnt;
        int  pick;
        cnt = 0;
        while (cnt < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                queue_req(REQ_SET, pick_freq(ref_clk_model), PHASE_W'($urandom));
                cnt++;
            end else if (pick < 75) begin
                queue_req(REQ_PDOWN, FREQ_W'($urandom), PHASE_W'($urandom));
                cnt++;
            end else if (pick < 90) begin
                queue_req(REQ_WAKE, FREQ_W'($urandom), PHASE_W'($urandom));
                cnt++;
            end else begin
                queue_req(REQ_NONE, FREQ_W'($urandom), PHASE_W'($urandom));
            end
        end
    endtask

    initial begin
        logic [FREQ_W-1:0] ref_list[N_PHASES];

        tw_model      = '0;
        phase_model   = '0;
        ref_clk_model = REF_RESET;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset reference clock of 125 MHz
        queue_req(REQ_WAKE, '1, '1);                  // wake before any set sends zeros
        queue_req(REQ_NONE, '1, '1);                  // dropped code
        queue_req(REQ_PDOWN, '0, '0);
        queue_req(REQ_SET, '0, '0);                   // zero frequency
        queue_req(REQ_SET, '1, '1);                   // far above reference, saturates
        queue_req(REQ_SET, FREQ_W'(124999999), 5'd21);  // just below reference
        queue_req(REQ_SET, FREQ_W'(125000000), 5'd10);  // equal to reference, saturates
        queue_req(REQ_SET, FREQ_W'(1), 5'd1);
        queue_req(REQ_SET, FREQ_W'(10000000), 5'd16);
        queue_req(REQ_PDOWN, '1, '1);                 // stored word must survive
        queue_req(REQ_WAKE, '0, '0);
        queue_req(REQ_SET, FREQ_W'(28'hAAAAAAA), 5'h0A);
        queue_req(REQ_SET, FREQ_W'(28'h5555555), 5'h15);
        queue_req(REQ_NONE, '0, '0);
        queue_req(REQ_WAKE, FREQ_W'($urandom), PHASE_W'($urandom));
        queue_req(REQ_SET, FREQ_W'(62500000), 5'd31);
        queue_req(REQ_PDOWN, '0, '1);
        queue_req(REQ_PDOWN, '1, '0);
        queue_req(REQ_WAKE, '1, '0);
        wait_drained();

        // reference clock settings: extremes, zero divisor, typical and random
        ref_list[0] = FREQ_W'(1);
        ref_list[1] = '1;
        ref_list[2] = '0;
        ref_list[3] = FREQ_W'(125000000);
        ref_list[4] = FREQ_W'(1000);
        ref_list[5] = FREQ_W'($urandom);
        ref_list[6] = FREQ_W'($urandom_range(1, 65535));
        ref_list[7] = FREQ_W'(10000000);

        for (int p = 0; p < N_PHASES; p++) begin
            write_ref_clk(ref_list[p]);
            // one phase runs without any idling on either side
            quiet = (p == 3);
            if (p == 2)
                queue_req(REQ_SET, '0, 5'd7);         // zero divisor with zero frequency
            queue_random(PHASE_ITEMS);
            wait_drained();
            quiet = 1'b0;
        end

        $display("covered %0d sets, %0d power downs, %0d wake ups, %0d dropped codes",
                 n_set, n_pdown, n_wake, n_ignored);
        $display("%0d serial events compared across %0d reference clock settings",
                 n_checked, n_settings);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
